[sv/stack_machine_evaluator_macros.svh]
// Assertion macros shared by the stack machine evaluator modules.
`ifndef STACK_MACHINE_EVALUATOR_MACROS_SVH
`define STACK_MACHINE_EVALUATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SME_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SME_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/sme_pkg.sv]
// Shared types and constants of the stack machine evaluator.
package sme_pkg;

  localparam int WORD_W      = 32;
  localparam int ACT_W       = 3;
  localparam int OUT_DEPTH_W = 7;
  localparam int CNT_W       = $clog2(WORD_W);

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD    = 3'd0,
    ACT_ADD     = 3'd1,
    ACT_SUB     = 3'd2,
    ACT_MUL     = 3'd3,
    ACT_MOD     = 3'd4,
    ACT_INC     = 3'd5,
    ACT_DEC     = 3'd6,
    ACT_UNKNOWN = 3'd7
  } action_t;

  typedef struct packed {
    logic accept;
    logic rd_second;
    logic rd_below;
    logic exec;
    logic div_step;
    logic div_fin;
    logic load_top;
    logic post;
  } cmd_t;

  typedef struct packed {
    action_t act;
    logic    err;
    logic    bin_ok;
    logic    div_zero;
    logic    div_last;
  } sts_t;

endpackage

[sv/sme_datapath.sv]
// Datapath: stack memory, top-of-stack register, ALU, serial divider, result register.
`include "stack_machine_evaluator_macros.svh"

module sme_datapath #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  sme_pkg::cmd_t                          cmd,
  output sme_pkg::sts_t                          sts,
  input  logic [sme_pkg::ACT_W-1:0]              in_action,
  input  logic signed [sme_pkg::WORD_W-1:0]      in_immediate,
  output logic                                   out_error_seen,
  output logic [sme_pkg::OUT_DEPTH_W-1:0]        out_stack_depth,
  output logic signed [sme_pkg::WORD_W-1:0]      out_top_value,
  output logic                                   out_answer_valid
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int W  = sme_pkg::WORD_W;

  logic [W-1:0]  mem [STACK_DEPTH];
  logic [W-1:0]  rdata_r;
  logic [W-1:0]  top_r, top_nxt;
  logic [CW-1:0] depth_r, depth_nxt;
  logic          err_r, err_nxt;
  sme_pkg::action_t act_r;
  logic [W-1:0]  imm_r;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  dvd_r, dvd_nxt;
  logic [W-1:0]  dsr_r, dsr_nxt;
  logic          neg_r, neg_nxt;
  logic [sme_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic          rd_en;
  logic          bin_ok;
  logic          full;
  logic [W-1:0]  first, second;
  logic [W:0]    rem_sh;
  logic          out_err_r;
  logic [sme_pkg::OUT_DEPTH_W-1:0] out_depth_r;
  logic [W-1:0]  out_top_r;
  logic          out_ans_r;

  assign first   = top_r;
  assign second  = rdata_r;
  assign bin_ok  = depth_r >= CW'(2);
  assign full    = depth_r == CW'(STACK_DEPTH);
  assign wr_addr = AW'(depth_r - CW'(1));
  assign rd_addr = cmd.rd_below ? AW'(depth_r - CW'(1)) : AW'(depth_r - CW'(2));
  assign rd_en   = cmd.rd_below | cmd.rd_second;
  assign rem_sh  = {rem_r, dvd_r[W-1]};

  assign sts.act      = act_r;
  assign sts.err      = err_r;
  assign sts.bin_ok   = bin_ok;
  assign sts.div_zero = second == '0;
  assign sts.div_last = cnt_r == {sme_pkg::CNT_W{1'b1}};

  always_comb begin
    top_nxt   = top_r;
    depth_nxt = depth_r;
    err_nxt   = err_r;
    rem_nxt   = rem_r;
    dvd_nxt   = dvd_r;
    dsr_nxt   = dsr_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    wr_en     = 1'b0;
    if (cmd.exec && !err_r) begin
      case (act_r)
        sme_pkg::ACT_LOAD: begin
          if (full) begin
            err_nxt = 1'b1;
          end else begin
            wr_en     = depth_r != '0;
            top_nxt   = imm_r;
            depth_nxt = depth_r + CW'(1);
          end
        end
        sme_pkg::ACT_ADD, sme_pkg::ACT_SUB, sme_pkg::ACT_MUL: begin
          if (!bin_ok) begin
            err_nxt = 1'b1;
          end else begin
            depth_nxt = depth_r - CW'(1);
            if (act_r == sme_pkg::ACT_ADD) begin
              top_nxt = first + second;
            end else if (act_r == sme_pkg::ACT_SUB) begin
              top_nxt = first - second;
            end else begin
              top_nxt = first * second;
            end
          end
        end
        sme_pkg::ACT_MOD: begin
          if (!bin_ok) begin
            err_nxt = 1'b1;
          end else if (second == '0) begin
            err_nxt   = 1'b1;
            depth_nxt = depth_r - CW'(2);
          end else begin
            neg_nxt = first[W-1];
            dvd_nxt = first[W-1] ? (W'(0) - first) : first;
            dsr_nxt = second[W-1] ? (W'(0) - second) : second;
            rem_nxt = '0;
            cnt_nxt = '0;
          end
        end
        sme_pkg::ACT_INC: begin
          if (depth_r == '0) begin
            err_nxt = 1'b1;
          end else begin
            top_nxt = top_r + W'(1);
          end
        end
        sme_pkg::ACT_DEC: begin
          if (depth_r == '0) begin
            err_nxt = 1'b1;
          end else begin
            top_nxt = top_r - W'(1);
          end
        end
        default: begin
          err_nxt = 1'b1;
        end
      endcase
    end
    if (cmd.div_step) begin
      if (rem_sh >= {1'b0, dsr_r}) begin
        rem_nxt = W'(rem_sh - {1'b0, dsr_r});
      end else begin
        rem_nxt = rem_sh[W-1:0];
      end
      dvd_nxt = {dvd_r[W-2:0], 1'b0};
      cnt_nxt = cnt_r + sme_pkg::CNT_W'(1);
    end
    if (cmd.div_fin) begin
      top_nxt   = neg_r ? (W'(0) - rem_r) : rem_r;
      depth_nxt = depth_r - CW'(1);
    end
    if (cmd.load_top) begin
      top_nxt = rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= top_r;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      err_r   <= 1'b0;
    end else begin
      depth_r <= depth_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    if (cmd.accept) begin
      act_r <= sme_pkg::action_t'(in_action);
      imm_r <= in_immediate;
    end
    if (cmd.post) begin
      out_err_r   <= err_r;
      out_depth_r <= sme_pkg::OUT_DEPTH_W'(depth_r);
      out_top_r   <= (depth_r != '0) ? top_r : '0;
      out_ans_r   <= !err_r && (depth_r == CW'(1));
    end
  end

  assign out_error_seen   = out_err_r;
  assign out_stack_depth  = out_depth_r;
  assign out_top_value    = out_top_r;
  assign out_answer_valid = out_ans_r;

  `SME_ASSERT_NEXT(a_err_sticky, clk, rst_n, err_r, err_r, "Error flag cleared without reset.")
  `SME_ASSERT_NEXT(a_err_freeze, clk, rst_n, err_r && cmd.exec,
    $stable(depth_r) && $stable(top_r), "Stack changed after an error.")
  `SME_ASSERT_NOW(a_depth_max, clk, rst_n, 1'b1, depth_r <= CW'(STACK_DEPTH),
    "Stack depth beyond capacity.")

endmodule

[sv/sme_ctrl.sv]
// Controller: request handshakes and sequencing of the datapath per instruction.
`include "stack_machine_evaluator_macros.svh"

module sme_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  sme_pkg::sts_t sts,
  output sme_pkg::cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_EXEC  = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_DFIN  = 6'b001000,
    ST_FETCH = 6'b010000,
    ST_LDTOP = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   pend_r, pend_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;
  logic   idle;

  assign idle      = state_r == ST_IDLE;
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = idle && (!pend_r || slot_free);
  assign out_valid = out_valid_r;

  assign cmd.accept    = in_valid && in_ready;
  assign cmd.rd_second = idle;
  assign cmd.rd_below  = state_r == ST_FETCH;
  assign cmd.exec      = state_r == ST_EXEC;
  assign cmd.div_step  = state_r == ST_DIV;
  assign cmd.div_fin   = state_r == ST_DFIN;
  assign cmd.load_top  = state_r == ST_LDTOP;
  assign cmd.post      = idle && pend_r && slot_free;

  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r && !cmd.post;
    out_valid_nxt = cmd.post || (out_valid_r && !out_ready);
    case (state_r)
      ST_IDLE: begin
        if (cmd.accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!sts.err && sts.act == sme_pkg::ACT_MOD && sts.bin_ok) begin
          state_nxt = sts.div_zero ? ST_FETCH : ST_DIV;
        end else begin
          state_nxt = ST_IDLE;
          pend_nxt  = 1'b1;
        end
      end
      ST_DIV: begin
        if (sts.div_last) begin
          state_nxt = ST_DFIN;
        end
      end
      ST_DFIN: begin
        state_nxt = ST_IDLE;
        pend_nxt  = 1'b1;
      end
      ST_FETCH: begin
        state_nxt = ST_LDTOP;
      end
      ST_LDTOP: begin
        state_nxt = ST_IDLE;
        pend_nxt  = 1'b1;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `SME_ASSERT_NEXT(a_accept_exec, clk, rst_n, cmd.accept, state_r == ST_EXEC,
    "Accepted request did not start execution.")
  `SME_ASSERT_NOW(a_pend_idle, clk, rst_n, pend_r, state_r == ST_IDLE,
    "Pending result outside the idle state.")
  `SME_ASSERT_NEXT(a_div_done, clk, rst_n, state_r == ST_DIV && sts.div_last,
    state_r == ST_DFIN, "Divider did not finish after its last step.")

endmodule

[sv/stack_machine_evaluator.sv]
// Top level of the stack machine evaluator: controller and datapath.
//
// Usage: each input request carries one instruction (in_action) and an
// immediate (in_immediate) that only load uses. Every request yields exactly
// one result request with the sticky error flag, the stack depth, the top
// value (zero when empty) and the answer-valid flag. Both channels use
// valid/ready handshakes.
// Sequencing: each instruction executes in the EXEC state and its result is then
// registered for output; mod runs through a one-bit-per-cycle divider (DIV, then
// DFIN), and a mod by zero loads the new top instead (FETCH, then LDTOP).
// Acceptance: a new instruction is taken only in the idle state, after the
// previous one has finished; the second operand comes from a registered read of
// the stack memory. Mod occupies the divider for 32 steps plus setup and finish.
// Reset: rst_n is synchronous and active low; it empties the stack and clears
// the error flag. Stack memory contents are not cleared.
// Stall: the result register holds while out_ready is low; one more request
// may finish behind it, after which in_ready stays low until the result is
// taken.
module stack_machine_evaluator #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [sme_pkg::ACT_W-1:0]              in_action,
  input  logic signed [sme_pkg::WORD_W-1:0]      in_immediate,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_error_seen,
  output logic [sme_pkg::OUT_DEPTH_W-1:0]        out_stack_depth,
  output logic signed [sme_pkg::WORD_W-1:0]      out_top_value,
  output logic                                   out_answer_valid
);

  sme_pkg::cmd_t cmd;
  sme_pkg::sts_t sts;

  sme_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sme_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_action        (in_action),
    .in_immediate     (in_immediate),
    .out_error_seen   (out_error_seen),
    .out_stack_depth  (out_stack_depth),
    .out_top_value    (out_top_value),
    .out_answer_valid (out_answer_valid)
  );

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the stack machine evaluator: directed table and random programs.
`timescale 1ns / 100ps

module tb_top;

  localparam int STACK_ENTRIES = 64;
  localparam int W  = sme_pkg::WORD_W;
  localparam int DW = sme_pkg::OUT_DEPTH_W;

  typedef struct packed {
    logic          err;
    logic [DW-1:0] depth;
    logic [W-1:0]  top;
    logic          ans;
  } result_t;

  typedef struct {
    sme_pkg::action_t act;
    logic [W-1:0]     imm;
    bit               typed;
    result_t          want;
  } row_t;

  typedef enum int {
    FAULT_FEW_OPERANDS,
    FAULT_ZERO_DIVISOR,
    FAULT_OVERFLOW,
    FAULT_UNKNOWN
  } fault_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [sme_pkg::ACT_W-1:0] in_action = '0;
  logic signed [W-1:0] in_immediate = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_error_seen;
  logic [DW-1:0] out_stack_depth;
  logic signed [W-1:0] out_top_value;
  logic out_answer_valid;

  logic [W-1:0] model_stack [STACK_ENTRIES];
  int model_depth = 0;
  bit model_fault = 1'b0;

  result_t pending_results [$];
  row_t opening_rows [$];
  bit quiet_stretch = 1'b0;
  int mismatches = 0;
  int results_checked = 0;
  int requests_sent = 0;
  int mods_sent = 0;
  int peak_depth = 0;
  fault_t closing_fault;

  stack_machine_evaluator #(
    .STACK_DEPTH(STACK_ENTRIES)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_action(in_action),
    .in_immediate(in_immediate),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_error_seen(out_error_seen),
    .out_stack_depth(out_stack_depth),
    .out_top_value(out_top_value),
    .out_answer_valid(out_answer_valid)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic result_t apply_instruction(sme_pkg::action_t act, logic [W-1:0] imm);
    logic [W-1:0] first;
    logic [W-1:0] second;
    logic [W-1:0] value;
    logic [W-1:0] mag_a;
    logic [W-1:0] mag_b;
    result_t r;
    if (!model_fault) begin
      case (act)
        sme_pkg::ACT_LOAD: begin
          if (model_depth >= STACK_ENTRIES) begin
            model_fault = 1'b1;
          end else begin
            model_stack[model_depth] = imm;
            model_depth++;
          end
        end
        sme_pkg::ACT_ADD, sme_pkg::ACT_SUB, sme_pkg::ACT_MUL, sme_pkg::ACT_MOD: begin
          if (model_depth < 2) begin
            model_fault = 1'b1;
          end else begin
            first = model_stack[model_depth-1];
            second = model_stack[model_depth-2];
            model_depth -= 2;
            if (act == sme_pkg::ACT_MOD && second == '0) begin
              model_fault = 1'b1;
            end else begin
              case (act)
                sme_pkg::ACT_ADD: value = first + second;
                sme_pkg::ACT_SUB: value = first - second;
                sme_pkg::ACT_MUL: value = first * second;
                default: begin
                  mag_a = first[W-1] ? -first : first;
                  mag_b = second[W-1] ? -second : second;
                  value = mag_a % mag_b;
                  if (first[W-1]) value = -value;
                end
              endcase
              model_stack[model_depth] = value;
              model_depth++;
            end
          end
        end
        sme_pkg::ACT_INC, sme_pkg::ACT_DEC: begin
          if (model_depth == 0) begin
            model_fault = 1'b1;
          end else if (act == sme_pkg::ACT_INC) begin
            model_stack[model_depth-1] = model_stack[model_depth-1] + 1;
          end else begin
            model_stack[model_depth-1] = model_stack[model_depth-1] - 1;
          end
        end
        default: model_fault = 1'b1;
      endcase
    end
    r.err = model_fault;
    r.depth = model_depth[DW-1:0];
    r.top = (model_depth > 0) ? model_stack[model_depth-1] : '0;
    r.ans = !model_fault && model_depth == 1;
    return r;
  endfunction

  function automatic row_t free_row(sme_pkg::action_t act, logic [W-1:0] imm);
    row_t r;
    r.act = act;
    r.imm = imm;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic row_t known_row(sme_pkg::action_t act, logic [W-1:0] imm, logic err,
                                     int depth, logic [W-1:0] top, logic ans);
    row_t r;
    r.act = act;
    r.imm = imm;
    r.typed = 1'b1;
    r.want.err = err;
    r.want.depth = depth[DW-1:0];
    r.want.top = top;
    r.want.ans = ans;
    return r;
  endfunction

  function automatic void add_row(row_t r);
    opening_rows = {opening_rows, r};
  endfunction

  function automatic logic [W-1:0] pick_immediate();
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(4))
          0: return 32'h0000_0000;
          1: return 32'h0000_0001;
          2: return 32'hFFFF_FFFF;
          3: return 32'h7FFF_FFFF;
          default: return 32'h8000_0000;
        endcase
      end
      1, 2: return $urandom_range(40) - 20;
      default: return $urandom;
    endcase
  endfunction

  function automatic sme_pkg::action_t choose_action(int target);
    int p;
    sme_pkg::action_t op;
    if (model_depth == 0) return sme_pkg::ACT_LOAD;
    if (model_depth < target) p = 70;
    else if (model_depth > target) p = 10;
    else p = 35;
    if (model_depth < STACK_ENTRIES && $urandom_range(99) < p) return sme_pkg::ACT_LOAD;
    if (model_depth < 2) return ($urandom_range(1) == 0) ? sme_pkg::ACT_INC : sme_pkg::ACT_DEC;
    op = sme_pkg::action_t'($urandom_range(sme_pkg::ACT_ADD, sme_pkg::ACT_DEC));
    if (op == sme_pkg::ACT_MOD && model_stack[model_depth-2] == '0) op = sme_pkg::ACT_SUB;
    return op;
  endfunction

  task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
    mismatches++;
    $display("mismatch %0d at %0t: %s got %h expected %h",
             mismatches, $realtime, what, got, want);
  endtask

  task automatic send_request(sme_pkg::action_t act, logic [W-1:0] imm, bit typed = 1'b0,
                              result_t want = '0);
    result_t predicted;
    result_t expected;
    if (!quiet_stretch && $urandom_range(99) < 12 && in_valid) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_immediate <= imm;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_instruction(act, imm);
    expected = typed ? want : predicted;
    pending_results = {pending_results, expected};
    requests_sent++;
    if (act == sme_pkg::ACT_MOD) mods_sent++;
    if (model_depth > peak_depth) peak_depth = model_depth;
  endtask

  task automatic hold_until_drained();
    if (in_valid) in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      out_ready <= quiet_stretch || ($urandom_range(99) >= 12);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, top", out_top_value, '0);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_error_seen !== want.err)
          report_mismatch("error_seen", W'(out_error_seen), W'(want.err));
        if (out_stack_depth !== want.depth)
          report_mismatch("stack_depth", W'(out_stack_depth), W'(want.depth));
        if (out_top_value !== want.top) report_mismatch("top_value", out_top_value, want.top);
        if (out_answer_valid !== want.ans)
          report_mismatch("answer_valid", W'(out_answer_valid), W'(want.ans));
      end
    end
  end

  initial begin
    int target;
    int burst_left;
    int random_sent;
    add_row(known_row(sme_pkg::ACT_LOAD, 32'h7FFF_FFFF, 1'b0, 1, 32'h7FFF_FFFF, 1'b1));
    add_row(known_row(sme_pkg::ACT_INC, 32'hFFFF_FFFF, 1'b0, 1, 32'h8000_0000, 1'b1));
    add_row(known_row(sme_pkg::ACT_DEC, 32'h0000_0000, 1'b0, 1, 32'h7FFF_FFFF, 1'b1));
    add_row(known_row(sme_pkg::ACT_LOAD, 32'hFFFF_FFFF, 1'b0, 2, 32'hFFFF_FFFF, 1'b0));
    add_row(free_row(sme_pkg::ACT_ADD, 32'h5A5A_A5A5));
    add_row(known_row(sme_pkg::ACT_LOAD, 32'h8000_0000, 1'b0, 2, 32'h8000_0000, 1'b0));
    add_row(free_row(sme_pkg::ACT_SUB, 32'hFFFF_FFFF));
    add_row(free_row(sme_pkg::ACT_LOAD, 32'h8000_0000));
    add_row(free_row(sme_pkg::ACT_MUL, 32'h0000_0000));
    add_row(free_row(sme_pkg::ACT_LOAD, 32'hFFFF_FFFF));
    add_row(free_row(sme_pkg::ACT_LOAD, 32'h8000_0000));
    add_row(known_row(sme_pkg::ACT_MOD, 32'h7FFF_FFFF, 1'b0, 2, 32'h0000_0000, 1'b0));
    add_row(free_row(sme_pkg::ACT_LOAD, 32'hFFFF_FFFD));
    add_row(free_row(sme_pkg::ACT_LOAD, 32'hFFFF_FFF9));
    add_row(free_row(sme_pkg::ACT_MOD, 32'h8000_0000));
    add_row(free_row(sme_pkg::ACT_LOAD, 32'h0000_0005));
    add_row(free_row(sme_pkg::ACT_LOAD, 32'hFFFF_FFF3));
    add_row(free_row(sme_pkg::ACT_MOD, 32'h0000_0001));
    add_row(free_row(sme_pkg::ACT_LOAD, 32'h1234_5678));
    add_row(free_row(sme_pkg::ACT_MUL, 32'hA5A5_5A5A));
    add_row(free_row(sme_pkg::ACT_MUL, 32'h0000_0000));
    add_row(free_row(sme_pkg::ACT_ADD, 32'hFFFF_FFFF));
    add_row(free_row(sme_pkg::ACT_SUB, 32'h0000_0000));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening_rows[i])
      send_request(opening_rows[i].act, opening_rows[i].imm, opening_rows[i].typed,
                   opening_rows[i].want);
    hold_until_drained();

    target = 1;
    burst_left = 0;
    random_sent = 0;
    while (random_sent < 1050) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(10, 60);
        case ($urandom_range(3))
          0: target = STACK_ENTRIES;
          1: target = 1;
          default: target = $urandom_range(1, STACK_ENTRIES);
        endcase
        if ($urandom_range(9) == 0) hold_until_drained();
      end
      quiet_stretch = random_sent >= 400 && random_sent < 600;
      send_request(choose_action(target), pick_immediate());
      burst_left--;
      random_sent++;
    end
    quiet_stretch = 1'b0;

    closing_fault = fault_t'($urandom_range(FAULT_UNKNOWN));
    if (closing_fault != FAULT_OVERFLOW)
      while (model_depth > 1) send_request(sme_pkg::ACT_ADD, pick_immediate());
    case (closing_fault)
      FAULT_FEW_OPERANDS:
        send_request(sme_pkg::action_t'($urandom_range(sme_pkg::ACT_ADD, sme_pkg::ACT_MOD)),
                     $urandom);
      FAULT_ZERO_DIVISOR: begin
        send_request(sme_pkg::ACT_LOAD, 32'h0000_0000);
        send_request(sme_pkg::ACT_MUL, $urandom);
        send_request(sme_pkg::ACT_LOAD, pick_immediate());
        send_request(sme_pkg::ACT_MOD, $urandom);
      end
      FAULT_OVERFLOW: begin
        while (model_depth < STACK_ENTRIES) send_request(sme_pkg::ACT_LOAD, pick_immediate());
        send_request(sme_pkg::ACT_LOAD, pick_immediate());
      end
      default: send_request(sme_pkg::ACT_UNKNOWN, $urandom);
    endcase
    repeat (40)
      send_request(sme_pkg::action_t'($urandom_range(sme_pkg::ACT_UNKNOWN)), $urandom);

    hold_until_drained();
    repeat (40) @(posedge clk);
    $display("covered %0d requests (%0d mod), %0d results checked, peak stack depth %0d",
             requests_sent, mods_sent, results_checked, peak_depth);
    $display("closing fault %s, then ignored requests; %0d mismatches",
             closing_fault.name(), mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
